FILE: rtl/lr23_pkg.sv
// ----------------------------------------------------------------------------
// lr23_pkg
// Types and constants shared by the 3/2 linear resampler modules.
// ----------------------------------------------------------------------------
package lr23_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = SAMPLE_W + 2;
    localparam int MAG_W    = SUM_W - 1;

    // ceil(2^17 / 3): exact floor(a / 3) for every a below 2^17
    localparam int          RECIP_SHIFT = 17;
    localparam logic [16:0] RECIP3      = 17'd43691;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // captured input item together with the resampler state it sees
    typedef struct packed {
        t_sample x;
        t_sample prev;
        logic    odd;
        logic    have;
        logic    last;
    } t_stage;

    typedef struct packed {
        t_sample sample;
        logic    last;
    } t_res;

    // up to three results of one input item, entry 0 goes out first
    typedef struct packed {
        logic [1:0]      count;
        t_res [2:0]      item;
    } t_res_set;

endpackage

FILE: rtl/lr23_interp.sv
// ----------------------------------------------------------------------------
// lr23_interp
// Weighted mean by three and assembly of the result set of one input item.
// ----------------------------------------------------------------------------
module lr23_interp (
    input  lr23_pkg::t_stage   i_stage,
    output lr23_pkg::t_res_set o_set
);

    logic signed [lr23_pkg::SUM_W-1:0]   prev_ext;
    logic signed [lr23_pkg::SUM_W-1:0]   x_ext;
    logic signed [lr23_pkg::SUM_W-1:0]   sum;
    logic                                neg;
    logic [lr23_pkg::SUM_W-1:0]          sum_abs;
    logic [lr23_pkg::MAG_W-1:0]          mag;
    logic [lr23_pkg::MAG_W+17-1:0]       prod;
    logic [lr23_pkg::MAG_W-1:0]          quot;
    logic [lr23_pkg::MAG_W-1:0]          quot_signed;
    lr23_pkg::t_sample                   mean;
    lr23_pkg::t_res                      mean_item;
    lr23_pkg::t_res                      x_item;
    lr23_pkg::t_res                      tail_item;

    assign prev_ext = lr23_pkg::SUM_W'(i_stage.prev);
    assign x_ext    = lr23_pkg::SUM_W'(i_stage.x);

    // odd index weights the new sample twice, even index the previous one
    assign sum = i_stage.odd ? (prev_ext + (x_ext <<< 1)) : ((prev_ext <<< 1) + x_ext);

    // divide magnitude by three, then restore the sign (truncate toward zero)
    assign neg     = sum[lr23_pkg::SUM_W-1];
    assign sum_abs = neg ? (~sum + 1'b1) : sum;
    assign mag     = sum_abs[lr23_pkg::MAG_W-1:0];
    assign prod    = mag * lr23_pkg::RECIP3;
    assign quot    = prod[lr23_pkg::MAG_W+lr23_pkg::RECIP_SHIFT-1:lr23_pkg::RECIP_SHIFT];
    assign quot_signed = neg ? (~quot + 1'b1) : quot;
    assign mean    = lr23_pkg::t_sample'(quot_signed[lr23_pkg::SAMPLE_W-1:0]);

    assign mean_item = '{sample: mean,      last: 1'b0};
    assign x_item    = '{sample: i_stage.x, last: 1'b0};
    assign tail_item = '{sample: i_stage.x, last: 1'b1};

    always_comb begin
        o_set = '0;
        priority if (i_stage.odd) begin
            o_set.item[0] = mean_item;
            o_set.item[1] = tail_item;
            o_set.count   = i_stage.last ? 2'd2 : 2'd1;
        end else if (i_stage.have) begin
            o_set.item[0] = mean_item;
            o_set.item[1] = x_item;
            o_set.item[2] = tail_item;
            o_set.count   = i_stage.last ? 2'd3 : 2'd2;
        end else begin
            o_set.item[0] = x_item;
            o_set.item[1] = tail_item;
            o_set.count   = i_stage.last ? 2'd2 : 2'd1;
        end
    end

endmodule

FILE: rtl/linear_resampler_two_to_three.sv
// ----------------------------------------------------------------------------
// linear_resampler_two_to_three
// Linear-interpolation upsampler by 3/2 for signed 16-bit audio streams.
// ----------------------------------------------------------------------------
// Usage:
//   Input samples arrive on the s_axis beats, tdata[15:0] the sample and
//   tlast on the final sample of a block. Results leave on the m_axis beats
//   in the same form; tlast marks the repeated final sample that closes
//   the block, after which the interpolation state starts over.
//   An even-indexed sample gives one or two results (the 2:1 mean with the
//   previous sample once one exists, then the sample), an odd-indexed one
//   gives the 1:2 mean; the final sample adds one more beat.
// Path: the first result of a sample passes the stage register and then
//   the result buffer, which takes it when the result buffer is free.
// Throughput: one result per cycle while the receiver is ready; the
//   single output channel sets the pace, and the stage register accepts
//   the next sample while the result buffer still drains.
// Reset (synchronous, active low) empties the stage and result buffer and
//   clears the state. A stalled receiver holds the current result steady;
//   input is refused while the stage register holds a sample that the buffer cannot take yet.
// ----------------------------------------------------------------------------
module linear_resampler_two_to_three (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] in_sample
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [15:0] out_sample
    output logic        o_m_axis_tlast
);

    logic                  s_fire;
    logic                  m_fire;
    logic                  load;
    lr23_pkg::t_sample     in_x;

    lr23_pkg::t_sample     r_prev;
    lr23_pkg::t_sample     n_prev;
    logic                  r_odd;
    logic                  n_odd;
    logic                  r_have;
    logic                  n_have;

    logic                  r_stage_valid;
    logic                  n_stage_valid;
    lr23_pkg::t_stage      r_stage;

    lr23_pkg::t_res_set    res_set;
    lr23_pkg::t_res [2:0]  r_q;
    lr23_pkg::t_res [2:0]  n_q;
    logic [1:0]            r_cnt;
    logic [1:0]            n_cnt;

    assign in_x   = lr23_pkg::t_sample'(i_s_axis_tdata);
    assign m_fire = (r_cnt != 2'd0) && i_m_axis_tready;
    // refill the buffer when it is empty or its last entry leaves now
    assign load   = r_stage_valid && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && m_fire));
    assign o_s_axis_tready = !r_stage_valid || load;
    assign s_fire = i_s_axis_tvalid && o_s_axis_tready;

    lr23_interp u_interp (
        .i_stage (r_stage),
        .o_set   (res_set)
    );

    // interpolation state advances at the input beat
    always_comb begin
        n_prev = r_prev;
        n_odd  = r_odd;
        n_have = r_have;
        if (s_fire) begin
            if (i_s_axis_tlast) begin
                n_prev = '0;
                n_odd  = 1'b0;
                n_have = 1'b0;
            end else begin
                n_prev = in_x;
                n_odd  = !r_odd;
                n_have = 1'b1;
            end
        end
    end

    always_comb begin
        n_stage_valid = r_stage_valid;
        if (s_fire) begin
            n_stage_valid = 1'b1;
        end else if (load) begin
            n_stage_valid = 1'b0;
        end
    end

    // result buffer: entry 0 is on the output, shift on each beat
    always_comb begin
        n_q   = r_q;
        n_cnt = r_cnt;
        if (load) begin
            n_q   = res_set.item;
            n_cnt = res_set.count;
        end else if (m_fire) begin
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
            n_cnt  = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev        <= '0;
            r_odd         <= 1'b0;
            r_have        <= 1'b0;
            r_stage_valid <= 1'b0;
            r_cnt         <= 2'd0;
        end else begin
            r_prev        <= n_prev;
            r_odd         <= n_odd;
            r_have        <= n_have;
            r_stage_valid <= n_stage_valid;
            r_cnt         <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_stage <= '{x: in_x, prev: r_prev, odd: r_odd, have: r_have,
                         last: i_s_axis_tlast};
        end
        r_q <= n_q;
    end

    assign o_m_axis_tvalid = (r_cnt != 2'd0);
    assign o_m_axis_tdata  = r_q[0].sample;
    assign o_m_axis_tlast  = r_q[0].last;

endmodule

FILE: rtl/lr23_check.sv
// ----------------------------------------------------------------------------
// lr23_check
// Port-level checks for the 3/2 linear resampler, bound to the top level.
// ----------------------------------------------------------------------------
module lr23_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,
    input  logic        i_s_axis_tlast,
    input  logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [15:0] o_m_axis_tdata,
    input  logic        o_m_axis_tlast
);

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // input is only refused while results are waiting
    a_backpressure_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with no result pending");

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            ($stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("result changed while stalled");

endmodule

bind linear_resampler_two_to_three lr23_check u_lr23_check (.*);

FILE: dv/lr23_checker.sv
// ----------------------------------------------------------------------------
// lr23_checker
// Watches both stream channels of the 3/2 resampler, predicts every output
// beat from the accepted input beats and compares them field by field.
// ----------------------------------------------------------------------------
module lr23_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] in_sample
    input  logic        i_s_axis_tlast,
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [15:0] i_m_axis_tdata,   // [15:0] out_sample
    input  logic        i_m_axis_tlast,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // interpolation state of the predictor
    lr23_pkg::t_sample prior_sample;
    logic              odd_index;
    logic              have_prior;

    lr23_pkg::t_res    resampled_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        prior_sample = '0;
        odd_index    = 1'b0;
        have_prior   = 1'b0;
    end

    // (2*near + far)/3, truncated toward zero
    function automatic lr23_pkg::t_sample third_mean(lr23_pkg::t_sample near,
                                                     lr23_pkg::t_sample far);
        int num;
        num = 2 * int'(near) + int'(far);
        return lr23_pkg::t_sample'(num / 3);
    endfunction

    task automatic predict_beat(lr23_pkg::t_sample x, logic last);
        if (odd_index) begin
            resampled_q.push_back('{sample: third_mean(x, prior_sample), last: 1'b0});
        end else begin
            if (have_prior) begin
                resampled_q.push_back('{sample: third_mean(prior_sample, x), last: 1'b0});
            end
            resampled_q.push_back('{sample: x, last: 1'b0});
        end
        if (last) begin
            // close the block with the repeated sample, then start over
            resampled_q.push_back('{sample: x, last: 1'b1});
            prior_sample = '0;
            odd_index    = 1'b0;
            have_prior   = 1'b0;
        end else begin
            prior_sample = x;
            have_prior   = 1'b1;
            odd_index    = !odd_index;
        end
    endtask

    always @(posedge i_clk) begin
        lr23_pkg::t_res got;
        lr23_pkg::t_res want;
        if (!i_rst_n) begin
            prior_sample = '0;
            odd_index    = 1'b0;
            have_prior   = 1'b0;
            resampled_q.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                predict_beat(lr23_pkg::t_sample'(i_s_axis_tdata), i_s_axis_tlast);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.sample = lr23_pkg::t_sample'(i_m_axis_tdata);
                got.last   = i_m_axis_tlast;
                if (resampled_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected output beat, expected none, %s %0d last %0b",
                             $time, "got sample", $signed(got.sample), got.last);
                end else begin
                    want = resampled_q.pop_front();
                    if (got.sample !== want.sample) begin
                        o_fail_count++;
                        $display("%0t: out_sample mismatch, expected %0d, got %0d",
                                 $time, $signed(want.sample), $signed(got.sample));
                    end
                    if (got.last !== want.last) begin
                        o_fail_count++;
                        $display("%0t: out_last mismatch, expected %0b, got %0b",
                                 $time, want.last, got.last);
                    end
                end
            end
        end
        o_pending = resampled_q.size();
    end

endmodule

FILE: dv/tb_linear_resampler_two_to_three.sv
// ----------------------------------------------------------------------------
// tb_linear_resampler_two_to_three
// Drives directed and random sample blocks into the 3/2 resampler with
// bursty input and a stalling receiver; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_linear_resampler_two_to_three;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 470;
    localparam int LIMIT_CYCLES = 200000;
    localparam int TAIL_CYCLES  = 20;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_RUNS
    } t_rx_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_data;   // [15:0] in_sample
    logic        s_last;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_data;   // [15:0] out_sample
    logic        m_last;

    int          fail_count;
    int          pending;
    int          cycle_count;

    int                burst_left;
    lr23_pkg::t_sample drawn_sample;
    int                items_sent;
    logic              mid_pause_done;

    t_rx_mode    rx_mode;
    int          rx_mode_left;
    int          rx_phase;
    int          rx_run_left;
    logic        rx_level;

    linear_resampler_two_to_three uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last)
    );

    lr23_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .i_m_axis_tlast  (m_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: switch between stall patterns every so often
    initial begin
        m_ready      = 1'b0;
        rx_mode      = RX_OPEN;
        rx_mode_left = 0;
        rx_phase     = 0;
        rx_run_left  = 0;
        rx_level     = 1'b1;
        forever begin
            @(negedge i_clk);
            if (rx_mode_left == 0) begin
                rx_mode      = t_rx_mode'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(32, 256);
            end
            rx_mode_left--;
            rx_phase++;
            case (rx_mode)
                RX_OPEN: begin
                    m_ready <= 1'b1;
                end
                RX_COIN: begin
                    m_ready <= 1'($urandom_range(0, 1));
                end
                RX_PERIODIC: begin
                    m_ready <= (rx_phase % 5) != 0;
                end
                default: begin
                    if (rx_run_left == 0) begin
                        rx_level    = !rx_level;
                        rx_run_left = $urandom_range(1, 20);
                    end
                    rx_run_left--;
                    m_ready <= rx_level;
                end
            endcase
        end
    end

    // one input beat, preceded by a gap whenever a burst runs out
    task automatic send_beat(lr23_pkg::t_sample sample, logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
            repeat (gap) begin
                @(negedge i_clk);
                s_valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge i_clk);
        s_valid <= 1'b1;
        s_data  <= sample;
        s_last  <= last;
        do @(posedge i_clk); while (!s_ready);
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic lr23_pkg::t_sample pick_sample();
        case ($urandom_range(0, 9))
            0:       drawn_sample = 16'sh7FFF;
            1:       drawn_sample = 16'sh8000;
            2:       drawn_sample = lr23_pkg::t_sample'(int'($urandom_range(0, 8)) - 4);
            3:       drawn_sample = lr23_pkg::t_sample'(int'(drawn_sample)
                                                        + int'($urandom_range(0, 6)) - 3);
            default: drawn_sample = lr23_pkg::t_sample'($urandom);
        endcase
        return drawn_sample;
    endfunction

    initial begin
        int blk_len;
        i_rst_n        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        s_last         = 1'b0;
        cycle_count    = 0;
        burst_left     = 0;
        drawn_sample   = '0;
        items_sent     = 0;
        mid_pause_done = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single-sample block at the top of the range
        send_beat(16'sh7FFF, 1'b1);
        // extremes, block closing on an odd index
        send_beat(16'sh8000, 1'b0);
        send_beat(16'sh7FFF, 1'b1);
        // means that must truncate toward zero, not down
        send_beat(16'sh0000, 1'b0);
        send_beat(16'shFFFF, 1'b0);
        send_beat(16'sh0000, 1'b0);
        send_beat(16'sh0001, 1'b0);
        send_beat(16'shFFFF, 1'b1);
        // alternating bit patterns and full swings
        send_beat(16'sh8000, 1'b0);
        send_beat(16'sh8000, 1'b0);
        send_beat(16'sh7FFF, 1'b0);
        send_beat(16'sh8000, 1'b0);
        send_beat(16'sh5555, 1'b0);
        send_beat(16'shAAAA, 1'b0);
        send_beat(16'shFFFE, 1'b1);
        send_beat(16'sh7FFF, 1'b0);
        send_beat(16'sh7FFF, 1'b1);
        // block closing on an even index with a previous sample
        send_beat(16'sh8000, 1'b0);
        send_beat(16'sh7FFF, 1'b0);
        send_beat(16'sh8000, 1'b1);

        // hold off until the directed results are all out
        drain_results();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       blk_len = 1;
                1:       blk_len = $urandom_range(30, 60);
                default: blk_len = $urandom_range(2, 12);
            endcase
            for (int i = 0; i < blk_len; i++) begin
                send_beat(pick_sample(), i == blk_len - 1);
            end
            if (!mid_pause_done && items_sent >= RANDOM_ITEMS / 2) begin
                mid_pause_done = 1'b1;
                drain_results();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/lr23_pkg.sv
rtl/lr23_interp.sv
rtl/linear_resampler_two_to_three.sv
rtl/lr23_check.sv
dv/lr23_checker.sv
dv/tb_linear_resampler_two_to_three.sv
